// ===== sv/oaf_pkg.sv =====
// ----------------------------------------------------------------------------
// oaf_pkg
// Shared types and constants for the obstacle-avoidance sequencer.
// ----------------------------------------------------------------------------
package oaf_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned DistW   = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned TolW    = 15;
  localparam int unsigned LinW    = 8;
  localparam int unsigned AngW    = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [ModeW-1:0] MODE_IDLE          = 3'd0;
  localparam logic [ModeW-1:0] MODE_PAUSE         = 3'd1;
  localparam logic [ModeW-1:0] MODE_DECIDE        = 3'd2;
  localparam logic [ModeW-1:0] MODE_TURN_CLEAR    = 3'd3;
  localparam logic [ModeW-1:0] MODE_TURN_PARALLEL = 3'd4;
  localparam logic [ModeW-1:0] MODE_FWD_PARALLEL  = 3'd5;
  localparam logic [ModeW-1:0] MODE_TURN_CHECK    = 3'd6;
  localparam logic [ModeW-1:0] MODE_FWD_CLEAR     = 3'd7;

  localparam logic [CfgIdxW-1:0] REG_MIN_DIST     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PAUSE        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAR_TURN     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FWD_PAR      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CHECK_TURN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FWD_CLEAR    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HEADING_TOL  = 3'd6;

  localparam logic signed [AngW-1:0] TURN_RATE   = 11'sd600;
  localparam logic [LinW-1:0]        DRIVE_SPEED = 8'd200;

  typedef struct packed {
    logic [DistW-1:0] min_distance_mm;
    logic [15:0]      pause_ms;
    logic [15:0]      parallel_turn_ms;
    logic [15:0]      forward_parallel_ms;
    logic [15:0]      check_turn_ms;
    logic [15:0]      forward_clear_ms;
    logic [TolW-1:0]  heading_tolerance;
  } oaf_cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode_now;
    logic [ModeW-1:0]  mode_next;
    logic [TimeW-1:0]  start_time;
    logic              turn_neg;
    logic [AngleW-1:0] start_heading;
  } oaf_state_t;

  typedef struct packed {
    logic              restart;
    logic [DistW-1:0]  left_mm;
    logic [DistW-1:0]  center_mm;
    logic [DistW-1:0]  right_mm;
    logic [AngleW-1:0] heading;
    logic [TimeW-1:0]  time_ms;
  } oaf_in_t;

  typedef struct packed {
    logic [ModeW-1:0]       current_mode;
    logic [ModeW-1:0]       pending_mode;
    logic                   outcome;
    logic [LinW-1:0]        linear;
    logic signed [AngW-1:0] angular;
  } oaf_res_t;

endpackage

// ===== sv/oaf_step.sv =====
// ----------------------------------------------------------------------------
// oaf_step
// One control step: mode update, timeouts, obstacle flags and commands.
// ----------------------------------------------------------------------------
module oaf_step import oaf_pkg::*; (
  input  oaf_cfg_t   cfg_i,
  input  oaf_state_t state_i,
  input  oaf_in_t    word_i,
  output oaf_state_t state_o,
  output oaf_res_t   res_o
);

  logic              ob_any;
  logic [TimeW-1:0]  elapsed;
  logic [AngleW-1:0] hdiff;
  logic [AngleW:0]   hmag;
  logic              hmatch;
  logic [ModeW-1:0]  mode_cur;
  logic [TimeW-1:0]  start_cur;
  logic signed [AngW-1:0] turn_cmd;

  always_comb begin
    ob_any = (word_i.left_mm < cfg_i.min_distance_mm) ||
             (word_i.center_mm < cfg_i.min_distance_mm) ||
             (word_i.right_mm < cfg_i.min_distance_mm);

    if (state_i.mode_next != state_i.mode_now) begin
      mode_cur  = state_i.mode_next;
      start_cur = word_i.time_ms;
    end else begin
      mode_cur  = state_i.mode_now;
      start_cur = state_i.start_time;
    end
    elapsed = word_i.time_ms - start_cur;

    hdiff  = word_i.heading - state_i.start_heading;
    hmag   = hdiff[AngleW-1] ? (17'h10000 - {1'b0, hdiff}) : {1'b0, hdiff};
    hmatch = hmag < {2'b00, cfg_i.heading_tolerance};

    turn_cmd = state_i.turn_neg ? -TURN_RATE : TURN_RATE;

    state_o            = state_i;
    state_o.mode_now   = mode_cur;
    state_o.start_time = start_cur;

    res_o         = '0;

    if (word_i.restart) begin
      state_o.mode_now   = MODE_IDLE;
      state_o.mode_next  = MODE_IDLE;
      state_o.start_time = word_i.time_ms;
    end else begin
      unique case (mode_cur)
        MODE_IDLE: begin
          state_o.mode_next = MODE_PAUSE;
        end
        MODE_PAUSE: begin
          if (elapsed > {16'd0, cfg_i.pause_ms}) begin
            state_o.start_heading = word_i.heading;
            if (ob_any) begin
              state_o.mode_next = MODE_DECIDE;
            end else begin
              res_o.outcome     = 1'b1;
              state_o.mode_next = MODE_IDLE;
            end
          end
        end
        MODE_DECIDE: begin
          if (ob_any) begin
            state_o.turn_neg  = word_i.left_mm < word_i.right_mm;
            state_o.mode_next = MODE_TURN_CLEAR;
          end else begin
            res_o.outcome     = 1'b1;
            state_o.mode_next = MODE_IDLE;
          end
        end
        MODE_TURN_CLEAR: begin
          res_o.angular = turn_cmd;
          if (!ob_any) state_o.mode_next = MODE_TURN_PARALLEL;
        end
        MODE_TURN_PARALLEL: begin
          res_o.angular = turn_cmd;
          if (elapsed > {16'd0, cfg_i.parallel_turn_ms}) begin
            state_o.mode_next = MODE_FWD_PARALLEL;
          end
        end
        MODE_FWD_PARALLEL: begin
          res_o.linear = DRIVE_SPEED;
          if (ob_any) begin
            state_o.mode_next = MODE_TURN_CLEAR;
          end else if (elapsed > {16'd0, cfg_i.forward_parallel_ms}) begin
            state_o.mode_next = MODE_TURN_CHECK;
          end
        end
        MODE_TURN_CHECK: begin
          res_o.angular = -turn_cmd;
          if (ob_any) begin
            state_o.mode_next = MODE_TURN_CLEAR;
          end else if (hmatch) begin
            res_o.outcome     = 1'b1;
            state_o.mode_next = MODE_IDLE;
          end else if (elapsed > {16'd0, cfg_i.check_turn_ms}) begin
            state_o.mode_next = MODE_FWD_CLEAR;
          end
        end
        default: begin
          res_o.linear = DRIVE_SPEED;
          if (ob_any) begin
            state_o.mode_next = MODE_TURN_CLEAR;
          end else if (elapsed > {16'd0, cfg_i.forward_clear_ms}) begin
            res_o.outcome     = 1'b1;
            state_o.mode_next = MODE_IDLE;
          end
        end
      endcase
    end

    res_o.current_mode = mode_cur;
    res_o.pending_mode = state_o.mode_next;
  end

endmodule

// ===== sv/obstacle_avoid_fsm.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_fsm
// Obstacle-avoidance sequencer for a rover, one result word per non-restart control step.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one sensor word per step
// (restart flag, three sonar distances, heading, ms timestamp).
// Output channel: out_valid_o / out_stall_i with mode, pending mode, outcome
// and velocity commands. A restart word returns the sequencer to idle and
// produces no result word.
// Path: input register, then step logic into the result register.
// Throughput: one word per cycle while out_stall_i is low; the sequencer
// state register is read and written in the same cycle, so consecutive
// steps follow back to back.
// Stall: while out_stall_i holds a result, one more word waits in the input
// register, then in_stall_o rises; restart words drain even under stall.
// Reset: asynchronous, active low; clears both pipeline valids, sets the
// sequencer to idle with zero timer and heading, and loads default registers.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// indexes beyond the register list are ignored. Write only while idle.
// ----------------------------------------------------------------------------
module obstacle_avoid_fsm import oaf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_restart_i,
  input  logic [DistW-1:0]       in_left_distance_mm_i,
  input  logic [DistW-1:0]       in_center_distance_mm_i,
  input  logic [DistW-1:0]       in_right_distance_mm_i,
  input  logic [AngleW-1:0]      in_heading_angle_i,
  input  logic [TimeW-1:0]       in_time_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ModeW-1:0]       out_current_mode_o,
  output logic [ModeW-1:0]       out_pending_mode_o,
  output logic                   out_outcome_o,
  output logic [LinW-1:0]        out_linear_mm_s_o,
  output logic signed [AngW-1:0] out_angular_mrad_s_o
);

  oaf_cfg_t   cfg_q;
  oaf_state_t state_q, state_d;
  oaf_in_t    word_q;
  oaf_res_t   res_q, res_d;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic       out_ready;
  logic       advance;
  logic       in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && (word_q.restart || out_ready);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance_mm     <= 16'd500;
      cfg_q.pause_ms            <= 16'd1000;
      cfg_q.parallel_turn_ms    <= 16'd800;
      cfg_q.forward_parallel_ms <= 16'd1500;
      cfg_q.check_turn_ms       <= 16'd2500;
      cfg_q.forward_clear_ms    <= 16'd3000;
      cfg_q.heading_tolerance   <= 15'd1043;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_DIST:    cfg_q.min_distance_mm     <= cfg_data_i;
        REG_PAUSE:       cfg_q.pause_ms            <= cfg_data_i;
        REG_PAR_TURN:    cfg_q.parallel_turn_ms    <= cfg_data_i;
        REG_FWD_PAR:     cfg_q.forward_parallel_ms <= cfg_data_i;
        REG_CHECK_TURN:  cfg_q.check_turn_ms       <= cfg_data_i;
        REG_FWD_CLEAR:   cfg_q.forward_clear_ms    <= cfg_data_i;
        REG_HEADING_TOL: cfg_q.heading_tolerance   <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q.restart   <= in_restart_i;
      word_q.left_mm   <= in_left_distance_mm_i;
      word_q.center_mm <= in_center_distance_mm_i;
      word_q.right_mm  <= in_right_distance_mm_i;
      word_q.heading   <= in_heading_angle_i;
      word_q.time_ms   <= in_time_ms_i;
    end
  end

  oaf_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .word_i  (word_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode_now      <= MODE_IDLE;
      state_q.mode_next     <= MODE_IDLE;
      state_q.start_time    <= '0;
      state_q.turn_neg      <= 1'b0;
      state_q.start_heading <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance && !word_q.restart;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !word_q.restart) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_current_mode_o   = res_q.current_mode;
  assign out_pending_mode_o   = res_q.pending_mode;
  assign out_outcome_o        = res_q.outcome;
  assign out_linear_mm_s_o    = res_q.linear;
  assign out_angular_mrad_s_o = res_q.angular;

  a_success_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.outcome |-> res_q.pending_mode == MODE_IDLE)
    else $error("success result without return to idle");

  a_drive_only_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.linear != '0) |->
      (res_q.current_mode == MODE_FWD_PARALLEL) || (res_q.current_mode == MODE_FWD_CLEAR))
    else $error("forward speed outside a forward mode");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held word");

  a_restart_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && word_q.restart |=>
      (state_q.mode_now == MODE_IDLE) && (state_q.mode_next == MODE_IDLE))
    else $error("restart did not return to idle");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("held result changed under stall");

endmodule

// ===== verif/obstacle_avoid_fsm_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obstacle_avoid_fsm_tb
// Self-checking bench for the obstacle-avoidance sequencer. A scoreboard
// class tracks the sequencer state and registers, predicts one command
// word per non-restart sensor word and compares each delivered command
// word field by field. A short directed run at reset defaults is followed
// by phases of random, mostly well-formed sensor streams under several
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module obstacle_avoid_fsm_tb;
  import oaf_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 250000;

  class avoid_scoreboard;
    oaf_cfg_t   cfg;
    oaf_state_t st;
    oaf_res_t   expected_cmds[$];
    int unsigned errors;

    function new();
      cfg.min_distance_mm     = 16'd500;
      cfg.pause_ms            = 16'd1000;
      cfg.parallel_turn_ms    = 16'd800;
      cfg.forward_parallel_ms = 16'd1500;
      cfg.check_turn_ms       = 16'd2500;
      cfg.forward_clear_ms    = 16'd3000;
      cfg.heading_tolerance   = 15'd1043;
      st.mode_now      = MODE_IDLE;
      st.mode_next     = MODE_IDLE;
      st.start_time    = '0;
      st.turn_neg      = 1'b0;
      st.start_heading = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_MIN_DIST:    cfg.min_distance_mm     = data;
        REG_PAUSE:       cfg.pause_ms            = data;
        REG_PAR_TURN:    cfg.parallel_turn_ms    = data;
        REG_FWD_PAR:     cfg.forward_parallel_ms = data;
        REG_CHECK_TURN:  cfg.check_turn_ms       = data;
        REG_FWD_CLEAR:   cfg.forward_clear_ms    = data;
        REG_HEADING_TOL: cfg.heading_tolerance   = data[TolW-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction

    function void note_sensor_word(oaf_in_t w);
      logic                   obstacle;
      logic                   heading_ok;
      logic [TimeW-1:0]       elapsed;
      logic [AngleW-1:0]      diff;
      logic [AngleW-1:0]      mag;
      logic signed [AngW-1:0] spin;
      oaf_res_t               r;
      if (w.restart) begin
        st.mode_now   = MODE_IDLE;
        st.mode_next  = MODE_IDLE;
        st.start_time = w.time_ms;
        return;
      end
      obstacle = (w.left_mm < cfg.min_distance_mm) || (w.center_mm < cfg.min_distance_mm) ||
                 (w.right_mm < cfg.min_distance_mm);
      if (st.mode_next != st.mode_now) begin
        st.start_time = w.time_ms;
        st.mode_now   = st.mode_next;
      end
      elapsed    = w.time_ms - st.start_time;
      spin       = st.turn_neg ? -TURN_RATE : TURN_RATE;
      diff       = w.heading - st.start_heading;
      mag        = diff[AngleW-1] ? -diff : diff;
      heading_ok = mag < cfg.heading_tolerance;
      r = '0;
      case (st.mode_now)
        MODE_IDLE: st.mode_next = MODE_PAUSE;
        MODE_PAUSE: begin
          if (elapsed > cfg.pause_ms) begin
            st.start_heading = w.heading;
            if (obstacle) begin
              st.mode_next = MODE_DECIDE;
            end else begin
              r.outcome    = 1'b1;
              st.mode_next = MODE_IDLE;
            end
          end
        end
        MODE_DECIDE: begin
          if (obstacle) begin
            st.turn_neg  = w.left_mm < w.right_mm;
            st.mode_next = MODE_TURN_CLEAR;
          end else begin
            r.outcome    = 1'b1;
            st.mode_next = MODE_IDLE;
          end
        end
        MODE_TURN_CLEAR: begin
          r.angular = spin;
          if (!obstacle) st.mode_next = MODE_TURN_PARALLEL;
        end
        MODE_TURN_PARALLEL: begin
          r.angular = spin;
          if (elapsed > cfg.parallel_turn_ms) st.mode_next = MODE_FWD_PARALLEL;
        end
        MODE_FWD_PARALLEL: begin
          r.linear = DRIVE_SPEED;
          if (obstacle) st.mode_next = MODE_TURN_CLEAR;
          else if (elapsed > cfg.forward_parallel_ms) st.mode_next = MODE_TURN_CHECK;
        end
        MODE_TURN_CHECK: begin
          r.angular = -spin;
          if (obstacle) begin
            st.mode_next = MODE_TURN_CLEAR;
          end else if (heading_ok) begin
            r.outcome    = 1'b1;
            st.mode_next = MODE_IDLE;
          end else if (elapsed > cfg.check_turn_ms) begin
            st.mode_next = MODE_FWD_CLEAR;
          end
        end
        default: begin
          r.linear = DRIVE_SPEED;
          if (obstacle) begin
            st.mode_next = MODE_TURN_CLEAR;
          end else if (elapsed > cfg.forward_clear_ms) begin
            r.outcome    = 1'b1;
            st.mode_next = MODE_IDLE;
          end
        end
      endcase
      r.current_mode = st.mode_now;
      r.pending_mode = st.mode_next;
      expected_cmds.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_command_word(oaf_res_t got);
      oaf_res_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command word, expected none, got %h", $time, got);
        return;
      end
      want = expected_cmds.pop_front();
      compare_field("current_mode", want.current_mode, got.current_mode);
      compare_field("pending_mode", want.pending_mode, got.pending_mode);
      compare_field("outcome", want.outcome, got.outcome);
      compare_field("linear_mm_s", want.linear, got.linear);
      compare_field("angular_mrad_s", int'(want.angular), int'(got.angular));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgW-1:0]        cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   in_restart_i;
  logic [DistW-1:0]       in_left_distance_mm_i;
  logic [DistW-1:0]       in_center_distance_mm_i;
  logic [DistW-1:0]       in_right_distance_mm_i;
  logic [AngleW-1:0]      in_heading_angle_i;
  logic [TimeW-1:0]       in_time_ms_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ModeW-1:0]       out_current_mode_o;
  logic [ModeW-1:0]       out_pending_mode_o;
  logic                   out_outcome_o;
  logic [LinW-1:0]        out_linear_mm_s_o;
  logic signed [AngW-1:0] out_angular_mrad_s_o;

  oaf_res_t        cmd_seen;
  avoid_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     idle_pct;
  int unsigned     cur_min;
  int unsigned     cur_tol;
  int unsigned     step_max;
  logic [TimeW-1:0]  t_now;
  logic [AngleW-1:0] base_heading;
  logic              blocked;

  obstacle_avoid_fsm dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .in_restart_i            (in_restart_i),
    .in_left_distance_mm_i   (in_left_distance_mm_i),
    .in_center_distance_mm_i (in_center_distance_mm_i),
    .in_right_distance_mm_i  (in_right_distance_mm_i),
    .in_heading_angle_i      (in_heading_angle_i),
    .in_time_ms_i            (in_time_ms_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .out_current_mode_o      (out_current_mode_o),
    .out_pending_mode_o      (out_pending_mode_o),
    .out_outcome_o           (out_outcome_o),
    .out_linear_mm_s_o       (out_linear_mm_s_o),
    .out_angular_mrad_s_o    (out_angular_mrad_s_o)
  );

  assign cmd_seen = {out_current_mode_o, out_pending_mode_o, out_outcome_o,
                     out_linear_mm_s_o, out_angular_mrad_s_o};

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // command side: check on accept, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_command_word(cmd_seen);
    out_stall_i <= ($urandom_range(99, 0) < idle_pct);
  end

  task automatic send_word(logic rs, logic [DistW-1:0] l, logic [DistW-1:0] c,
                           logic [DistW-1:0] r, logic [AngleW-1:0] h, logic [TimeW-1:0] t);
    oaf_in_t w;
    w = {rs, l, c, r, h, t};
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    in_restart_i            <= rs;
    in_left_distance_mm_i   <= l;
    in_center_distance_mm_i <= c;
    in_right_distance_mm_i  <= r;
    in_heading_angle_i      <= h;
    in_time_ms_i            <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sensor_word(w);
  endtask

  task automatic program_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // drain all command words, then allow a trailing restart word to clear
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [DistW-1:0] near_mm();
    return (cur_min == 0) ? '0 : DistW'($urandom_range(cur_min - 1, 0));
  endfunction

  function automatic logic [DistW-1:0] far_mm();
    return DistW'($urandom_range(65535, cur_min));
  endfunction

  task automatic random_words(int n);
    logic              rs;
    logic [DistW-1:0]  l, c, r;
    logic [AngleW-1:0] h, off;
    logic [2:0]        pick;
    for (int k = 0; k < n; k++) begin
      rs = ($urandom_range(99, 0) < 3);
      if ($urandom_range(99, 0) < 2) t_now = $urandom();
      else t_now = t_now + $urandom_range(step_max, 0);
      if ($urandom_range(99, 0) < 25) blocked = !blocked;
      if ($urandom_range(99, 0) < 10) begin
        l = DistW'($urandom());
        c = DistW'($urandom());
        r = DistW'($urandom());
      end else begin
        l = far_mm();
        c = far_mm();
        r = far_mm();
        if (blocked) begin
          pick = 3'($urandom_range(7, 1));
          if (pick[0]) l = near_mm();
          if (pick[1]) c = near_mm();
          if (pick[2]) r = near_mm();
        end
      end
      if ($urandom_range(99, 0) < 5) base_heading = AngleW'($urandom());
      if ($urandom_range(99, 0) < 40) begin
        h = AngleW'($urandom());
      end else begin
        off = AngleW'($urandom_range(cur_tol + cur_tol / 4 + 2, 0));
        h = $urandom_range(1, 0) ? base_heading + off : base_heading - off;
      end
      send_word(rs, l, c, r, h, t_now);
    end
  endtask

  task automatic run_phase(logic [CfgW-1:0] min_mm, logic [CfgW-1:0] pause,
                           logic [CfgW-1:0] par_turn, logic [CfgW-1:0] fwd_par,
                           logic [CfgW-1:0] chk_turn, logic [CfgW-1:0] fwd_clr,
                           logic [CfgW-1:0] tol, int n, int idle, int tstep);
    settle();
    program_reg(REG_MIN_DIST, min_mm);
    program_reg(REG_PAUSE, pause);
    program_reg(REG_PAR_TURN, par_turn);
    program_reg(REG_FWD_PAR, fwd_par);
    program_reg(REG_CHECK_TURN, chk_turn);
    program_reg(REG_FWD_CLEAR, fwd_clr);
    program_reg(REG_HEADING_TOL, tol);
    if ($urandom_range(1, 0)) program_reg(REG_UNUSED, CfgW'($urandom()));
    cfg_we_i <= 1'b0;
    cur_min  = 32'(min_mm);
    cur_tol  = 32'(tol[TolW-1:0]);
    idle_pct = idle;
    step_max = tstep;
    random_words(n);
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_restart_i = 1'b0;
    in_left_distance_mm_i = '0;
    in_center_distance_mm_i = '0;
    in_right_distance_mm_i = '0;
    in_heading_angle_i = '0;
    in_time_ms_i = '0;
    idle_pct = 30;
    t_now = '0;
    base_heading = '0;
    blocked = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk at reset defaults: timer boundaries, threshold edge,
    // turn side, half-turn and tolerance edge, restart, timestamp wrap
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd0);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd100);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd1100);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h1234, 32'd1101);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h1234, 32'd1102);
    send_word(1'b0, 16'hFFFF, 16'd499, 16'hFFFF, 16'h1234, 32'd1103);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd1104);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd1905);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd2705);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd2706);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd2707);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1234, 32'd4208);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h9234, 32'd4209);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h1647, 32'd4210);
    send_word(1'b0, 16'd500, 16'd500, 16'd500, 16'h0E22, 32'd4211);
    send_word(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 32'hFFFF_FFF0);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF8);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF9);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_03E2);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd995);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd996);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 32'd2000);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 32'd2001);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 32'd2002);

    run_phase(16'd1000, 16'd20, 16'd15, 16'd30, 16'd40, 16'd25, 16'd3000, 300, 30, 10);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 150, 30, 3);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              200, 30, 20000);
    run_phase(CfgW'($urandom_range(3000, 200)), CfgW'($urandom_range(60, 0)),
              CfgW'($urandom_range(60, 0)), CfgW'($urandom_range(60, 0)),
              CfgW'($urandom_range(60, 0)), CfgW'($urandom_range(60, 0)),
              CfgW'($urandom_range(8000, 0)), 400, 0, 15);
    run_phase(CfgW'($urandom_range(2000, 100)), CfgW'($urandom_range(40, 0)),
              CfgW'($urandom_range(40, 0)), CfgW'($urandom_range(40, 0)),
              CfgW'($urandom_range(80, 0)), CfgW'($urandom_range(40, 0)),
              CfgW'($urandom_range(32767, 0)), 400, 30, 12);
    run_phase(CfgW'($urandom()), CfgW'($urandom_range(100, 0)),
              CfgW'($urandom_range(100, 0)), CfgW'($urandom_range(100, 0)),
              CfgW'($urandom_range(100, 0)), CfgW'($urandom_range(100, 0)),
              CfgW'($urandom()), 250, 30, 30);
    settle();
    program_reg(REG_UNUSED, CfgW'($urandom()));
    cfg_we_i <= 1'b0;
    run_phase(16'd500, 16'd1000, 16'd800, 16'd1500, 16'd2500, 16'd3000, 16'd1043,
              200, 30, 400);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
